>>> design/i2cx_pkg.sv
package i2cx_pkg;

    // Field widths fixed by the bus event and result formats
    localparam int PIN_W     = 16;
    localparam int POT_SLOTS = 4;
    localparam int POT_SEL_W = 2;

    localparam int PIN_COUNT_DEF = 16;
    localparam int POT_COUNT_DEF = 4;

    localparam logic [7:0] POT_RESET_LEVEL = 8'd200;
    localparam logic [15:0] LOW_BYTE_MASK  = 16'h00FF;
    localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;

    typedef enum logic [2:0] {
        ACT_WRITE_START = 3'd0,
        ACT_BYTE_RX     = 3'd1,
        ACT_READ_START  = 3'd2,
        ACT_BYTE_SENT   = 3'd3,
        ACT_BUS_END     = 3'd4,
        ACT_SPI_IDLE    = 3'd5
    } act_t;

    localparam logic [7:0] OP_SET_LEGACY  = 8'h01;
    localparam logic [7:0] OP_SET_CHANNEL = 8'h02;
    localparam logic [7:0] OP_SET_LED     = 8'h10;
    localparam logic [7:0] OP_SET_POT     = 8'h20;
    localparam logic [7:0] OP_READ_POTS   = 8'h21;
    localparam logic [7:0] OP_SET_CLOCK   = 8'h31;
    localparam logic [7:0] OP_SET_DIR     = 8'h40;
    localparam logic [7:0] OP_SET_DRIVE   = 8'h41;
    localparam logic [7:0] OP_SET_PIN     = 8'h42;
    localparam logic [7:0] OP_READ_PINS   = 8'h43;

    localparam logic [2:0] TX_LEN_LEGACY = 3'd1;
    localparam logic [2:0] TX_LEN_PINS   = 3'd2;
    localparam logic [2:0] TX_LEN_POTS   = 3'd4;

    typedef struct packed {
        logic                 tx_valid;
        logic [7:0]           tx_byte;
        logic                 tx_last;
        logic [PIN_W-1:0]     pin_direction;
        logic [PIN_W-1:0]     pin_drive;
        logic                 led_on;
        logic                 pot_start;
        logic [POT_SEL_W-1:0] pot_select;
        logic [7:0]           pot_level;
    } res_t;

    function automatic logic [2:0] opcode_length(input logic [7:0] op);
        logic [2:0] len;
        case (op)
            OP_SET_LEGACY:  len = 3'd2;
            OP_SET_CHANNEL: len = 3'd3;
            OP_SET_LED:     len = 3'd2;
            OP_SET_POT:     len = 3'd3;
            OP_SET_CLOCK:   len = 3'd7;
            OP_SET_DIR:     len = 3'd3;
            OP_SET_DRIVE:   len = 3'd3;
            OP_SET_PIN:     len = 3'd3;
            default:        len = 3'd1;
        endcase
        return len;
    endfunction

endpackage

>>> design/i2cx_evt_if.sv
interface i2cx_evt_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   action;
    logic [7:0]                   data_byte;
    logic [i2cx_pkg::PIN_W-1:0]   pin_levels;

    modport source (output valid, output action, output data_byte, output pin_levels,
                    input ready);
    modport sink   (input valid, input action, input data_byte, input pin_levels,
                    output ready);
endinterface

>>> design/i2cx_res_if.sv
interface i2cx_res_if;
    logic                             valid;
    logic                             ready;
    logic                             tx_valid;
    logic [7:0]                       tx_byte;
    logic                             tx_last;
    logic [i2cx_pkg::PIN_W-1:0]       pin_direction;
    logic [i2cx_pkg::PIN_W-1:0]       pin_drive;
    logic                             led_on;
    logic                             pot_start;
    logic [i2cx_pkg::POT_SEL_W-1:0]   pot_select;
    logic [7:0]                       pot_level;

    modport source (output valid, output tx_valid, output tx_byte, output tx_last,
                    output pin_direction, output pin_drive, output led_on,
                    output pot_start, output pot_select, output pot_level,
                    input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input tx_last,
                    input pin_direction, input pin_drive, input led_on,
                    input pot_start, input pot_select, input pot_level,
                    output ready);
endinterface

>>> design/i2cx_core.sv
module i2cx_core #(
    parameter int PIN_COUNT = i2cx_pkg::PIN_COUNT_DEF,
    parameter int POT_COUNT = i2cx_pkg::POT_COUNT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [2:0]                   action,
    input  logic [7:0]                   data_byte,
    input  logic [i2cx_pkg::PIN_W-1:0]   pin_levels,
    output i2cx_pkg::res_t               result
);

    localparam logic [i2cx_pkg::PIN_W-1:0] PIN_MASK =
        i2cx_pkg::PIN_W'((32'd1 << PIN_COUNT) - 32'd1);
    localparam logic [POT_COUNT-1:0] POT_MASK = {POT_COUNT{1'b1}};

    logic        rx_active_reg, rx_active_next;
    logic [2:0]  rx_count_reg, rx_count_next;
    logic [2:0]  rx_expected_reg, rx_expected_next;
    logic [7:0]  rx_bytes_reg [3];
    logic [7:0]  rx_bytes_next [3];
    logic [2:0]  tx_length_reg, tx_length_next;
    logic [2:0]  tx_index_reg, tx_index_next;
    logic [7:0]  tx_bytes_reg [i2cx_pkg::POT_SLOTS];
    logic [7:0]  tx_bytes_next [i2cx_pkg::POT_SLOTS];
    logic        read_pins_reg, read_pins_next;
    logic        read_pots_reg, read_pots_next;
    logic [i2cx_pkg::PIN_W-1:0] dir_mask_reg, dir_mask_next;
    logic [i2cx_pkg::PIN_W-1:0] out_mask_reg, out_mask_next;
    logic        led_reg, led_next;
    logic [7:0]  pot_values_reg [i2cx_pkg::POT_SLOTS];
    logic [7:0]  pot_values_next [i2cx_pkg::POT_SLOTS];
    logic [POT_COUNT-1:0] pot_pending_reg, pot_pending_next;

    always_comb
    begin
        logic                       run;
        logic [2:0]                 cnt_inc;
        logic [2:0]                 len;
        logic [2:0]                 idx_inc;
        logic [7:0]                 op;
        logic [7:0]                 a;
        logic [7:0]                 b;
        logic [7:0]                 m;
        logic [i2cx_pkg::PIN_W-1:0] bitm;
        logic [i2cx_pkg::PIN_W-1:0] lv;
        logic                       found;

        rx_active_next   = rx_active_reg;
        rx_count_next    = rx_count_reg;
        rx_expected_next = rx_expected_reg;
        rx_bytes_next    = rx_bytes_reg;
        tx_length_next   = tx_length_reg;
        tx_index_next    = tx_index_reg;
        tx_bytes_next    = tx_bytes_reg;
        read_pins_next   = read_pins_reg;
        read_pots_next   = read_pots_reg;
        dir_mask_next    = dir_mask_reg;
        out_mask_next    = out_mask_reg;
        led_next         = led_reg;
        pot_values_next  = pot_values_reg;
        pot_pending_next = pot_pending_reg;

        result  = '0;
        run     = 1'b0;
        found   = 1'b0;
        cnt_inc = rx_count_reg + 3'd1;
        idx_inc = tx_index_reg + 3'd1;
        len     = i2cx_pkg::opcode_length(data_byte);
        lv      = pin_levels & PIN_MASK;

        if (accept)
        begin
            case (i2cx_pkg::act_t'(action))
                i2cx_pkg::ACT_WRITE_START:
                begin
                    rx_active_next   = 1'b1;
                    rx_count_next    = 3'd0;
                    rx_expected_next = 3'd1;
                end
                i2cx_pkg::ACT_BYTE_RX:
                begin
                    if (rx_active_reg)
                    begin
                        if (rx_count_reg < 3'd3)
                            rx_bytes_next[rx_count_reg[1:0]] = data_byte;
                        rx_count_next = cnt_inc;
                        if (cnt_inc == 3'd1)
                        begin
                            rx_expected_next = len;
                            if (len == 3'd1)
                            begin
                                run            = 1'b1;
                                rx_active_next = 1'b0;
                                tx_length_next = 3'd0;
                                tx_index_next  = 3'd0;
                            end
                        end
                        else if (cnt_inc >= rx_expected_reg)
                        begin
                            run            = 1'b1;
                            rx_active_next = 1'b0;
                        end
                    end
                end
                i2cx_pkg::ACT_READ_START:
                begin
                    tx_index_next = 3'd0;
                    if (read_pins_reg)
                    begin
                        read_pins_next   = 1'b0;
                        tx_length_next   = i2cx_pkg::TX_LEN_PINS;
                        tx_bytes_next[0] = lv[7:0];
                        tx_bytes_next[1] = lv[15:8];
                    end
                    else if (read_pots_reg)
                    begin
                        read_pots_next = 1'b0;
                        tx_length_next = i2cx_pkg::TX_LEN_POTS;
                        for (int i = 0; i < i2cx_pkg::POT_SLOTS; i++)
                            tx_bytes_next[i] = (i < POT_COUNT) ? pot_values_reg[i] : 8'd0;
                    end
                    else
                    begin
                        tx_length_next   = i2cx_pkg::TX_LEN_LEGACY;
                        tx_bytes_next[0] = out_mask_reg[7:0];
                    end
                    result.tx_valid = 1'b1;
                    result.tx_byte  = tx_bytes_next[0];
                    result.tx_last  = (tx_length_next == i2cx_pkg::TX_LEN_LEGACY);
                end
                i2cx_pkg::ACT_BYTE_SENT:
                begin
                    if ((tx_length_reg > 3'd1) && (tx_index_reg < tx_length_reg))
                    begin
                        tx_index_next = idx_inc;
                        if (idx_inc < tx_length_reg)
                        begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = tx_bytes_reg[idx_inc[1:0]];
                            result.tx_last  = ((idx_inc + 3'd1) == tx_length_reg);
                        end
                    end
                end
                i2cx_pkg::ACT_BUS_END:
                begin
                    rx_active_next = 1'b0;
                    tx_length_next = 3'd0;
                    tx_index_next  = 3'd0;
                end
                i2cx_pkg::ACT_SPI_IDLE:
                begin
                    // lowest pending pot goes first
                    for (int i = 0; i < POT_COUNT; i++)
                    begin
                        if (!found && pot_pending_reg[i])
                        begin
                            found               = 1'b1;
                            pot_pending_next[i] = 1'b0;
                            result.pot_start    = 1'b1;
                            result.pot_select   = i2cx_pkg::POT_SEL_W'(i);
                            result.pot_level    = pot_values_reg[i];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        op = rx_bytes_next[0];
        a  = rx_bytes_next[1];
        b  = rx_bytes_next[2];
        m  = out_mask_reg[7:0];
        bitm = i2cx_pkg::PIN_W'(1) << a[3:0];

        if (run)
        begin
            case (op)
                i2cx_pkg::OP_SET_LEGACY:
                begin
                    dir_mask_next = (dir_mask_reg | i2cx_pkg::LOW_BYTE_MASK) & PIN_MASK;
                    out_mask_next = ((out_mask_reg & i2cx_pkg::HIGH_BYTE_MASK)
                                    | {8'd0, a}) & PIN_MASK;
                end
                i2cx_pkg::OP_SET_CHANNEL:
                begin
                    if (a < 8'd8)
                    begin
                        if (b != 8'd0)
                            m = m | (8'd1 << a[2:0]);
                        else
                            m = m & ~(8'd1 << a[2:0]);
                        dir_mask_next = (dir_mask_reg | i2cx_pkg::LOW_BYTE_MASK) & PIN_MASK;
                        out_mask_next = ((out_mask_reg & i2cx_pkg::HIGH_BYTE_MASK)
                                        | {8'd0, m}) & PIN_MASK;
                    end
                end
                i2cx_pkg::OP_SET_LED:
                    led_next = (a != 8'd0);
                i2cx_pkg::OP_SET_POT:
                begin
                    for (int i = 0; i < POT_COUNT; i++)
                    begin
                        if (a == 8'(i))
                        begin
                            pot_values_next[i]  = b;
                            pot_pending_next[i] = 1'b1;
                        end
                    end
                end
                i2cx_pkg::OP_READ_POTS:
                    read_pots_next = 1'b1;
                i2cx_pkg::OP_SET_DIR:
                    dir_mask_next = {b, a} & PIN_MASK;
                i2cx_pkg::OP_SET_DRIVE:
                    out_mask_next = {b, a} & PIN_MASK;
                i2cx_pkg::OP_SET_PIN:
                begin
                    if (a < 8'(PIN_COUNT))
                    begin
                        dir_mask_next = (dir_mask_reg | bitm) & PIN_MASK;
                        if (b != 8'd0)
                            out_mask_next = out_mask_reg | bitm;
                        else
                            out_mask_next = out_mask_reg & ~bitm;
                    end
                end
                i2cx_pkg::OP_READ_PINS:
                    read_pins_next = 1'b1;
                default:
                begin
                end
            endcase
        end

        result.pin_direction = dir_mask_next;
        result.pin_drive     = out_mask_next;
        result.led_on        = led_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_active_reg   <= 1'b0;
            rx_count_reg    <= 3'd0;
            rx_expected_reg <= 3'd0;
            tx_length_reg   <= 3'd0;
            tx_index_reg    <= 3'd0;
            read_pins_reg   <= 1'b0;
            read_pots_reg   <= 1'b0;
            dir_mask_reg    <= '0;
            out_mask_reg    <= '0;
            led_reg         <= 1'b0;
            pot_pending_reg <= POT_MASK;
            for (int i = 0; i < i2cx_pkg::POT_SLOTS; i++)
                pot_values_reg[i] <= i2cx_pkg::POT_RESET_LEVEL;
        end
        else
        begin
            rx_active_reg   <= rx_active_next;
            rx_count_reg    <= rx_count_next;
            rx_expected_reg <= rx_expected_next;
            tx_length_reg   <= tx_length_next;
            tx_index_reg    <= tx_index_next;
            read_pins_reg   <= read_pins_next;
            read_pots_reg   <= read_pots_next;
            dir_mask_reg    <= dir_mask_next;
            out_mask_reg    <= out_mask_next;
            led_reg         <= led_next;
            pot_pending_reg <= pot_pending_next;
            pot_values_reg  <= pot_values_next;
        end
    end

    // frame and response bytes are only read after being written
    always_ff @(posedge clk)
    begin
        rx_bytes_reg <= rx_bytes_next;
        tx_bytes_reg <= tx_bytes_next;
    end

endmodule

>>> design/i2c_expander_command_engine_top.sv
// I2C expander command engine.
// evt (sink): one bus event per beat - write start, byte received, read
//   start, byte sent, bus end, SPI idle - with the received byte and the
//   sampled pin levels.
// res (source): exactly one beat per event, carrying the byte to send (if
//   any) with its last mark, the direction/drive masks and lamp state after
//   the event, and a pot write request on SPI idle.
// The result of an event is registered in the result register, or in the skid while res stalls.
// Throughput: one event per cycle while evt.ready is high; all state updates are
//   combinational logic between the state registers and the result register.
// Backpressure: a two-entry output stage (result register plus skid) lets
//   evt keep taking beats while res stalls; evt.ready drops only once both
//   entries hold results, and rises again the cycle after res drains one.
// Reset: all control state clears, pots reset to level 200 with every pot
//   pending, and both output entries are emptied.
module i2c_expander_command_engine_top #(
    parameter int PIN_COUNT = i2cx_pkg::PIN_COUNT_DEF,
    parameter int POT_COUNT = i2cx_pkg::POT_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    i2cx_evt_if.sink    evt,
    i2cx_res_if.source  res
);

    i2cx_pkg::res_t result;
    i2cx_pkg::res_t out_reg, out_next;
    i2cx_pkg::res_t skid_reg, skid_next;
    logic           out_valid_reg, out_valid_next;
    logic           skid_valid_reg, skid_valid_next;
    logic           accept;
    logic           take;

    assign evt.ready = !skid_valid_reg;
    assign accept    = evt.valid && !skid_valid_reg;
    assign take      = out_valid_reg && res.ready;

    i2cx_core #(
        .PIN_COUNT (PIN_COUNT),
        .POT_COUNT (POT_COUNT)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .action     (evt.action),
        .data_byte  (evt.data_byte),
        .pin_levels (evt.pin_levels),
        .result     (result)
    );

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign res.valid         = out_valid_reg;
    assign res.tx_valid      = out_reg.tx_valid;
    assign res.tx_byte       = out_reg.tx_byte;
    assign res.tx_last       = out_reg.tx_last;
    assign res.pin_direction = out_reg.pin_direction;
    assign res.pin_drive     = out_reg.pin_drive;
    assign res.led_on        = out_reg.led_on;
    assign res.pot_start     = out_reg.pot_start;
    assign res.pot_select    = out_reg.pot_select;
    assign res.pot_level     = out_reg.pot_level;

endmodule
